FILE: sv/feature_range_normalizer_assert.svh
// assertion macros shared by the feature range normaliser rtl
`ifndef FEATURE_RANGE_NORMALIZER_ASSERT_SVH
`define FEATURE_RANGE_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FRN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FRN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FRN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FRN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/frn_pkg.sv
// types, constants and helper functions of the feature range normaliser
`timescale 1ns / 1ps
package frn_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DEF_ENTRIES = 64;

  // iterative units
  localparam int DIV_STEPS    = VALUE_BITS + 1 + FRAC_BITS;
  localparam int DIV_CW       = $clog2(DIV_STEPS);
  localparam int CORDIC_STEPS = FRAC_BITS + 1;
  localparam int CORDIC_CW    = $clog2(CORDIC_STEPS);
  localparam int CW           = VALUE_BITS + 3;

  // fixed-point constants
  localparam logic signed [VALUE_BITS-1:0] ONE =
    VALUE_BITS'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [VALUE_BITS-1:0] T95 =
    VALUE_BITS'(((64'sd95 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam logic [27:0] KQ32 = 28'd136713055;

  // opcodes
  localparam logic [2:0] OP_DEFINE    = 3'd0;
  localparam logic [2:0] OP_BLANK     = 3'd1;
  localparam logic [2:0] OP_WIDEN_IN  = 3'd2;
  localparam logic [2:0] OP_WIDEN_OUT = 3'd3;
  localparam logic [2:0] OP_SET_IN    = 3'd4;
  localparam logic [2:0] OP_SET_OUT   = 3'd5;
  localparam logic [2:0] OP_NORM      = 3'd6;
  localparam logic [2:0] OP_NONE      = 3'd7;

  // options
  localparam logic [3:0] OPT_LINEAR      = 4'd0;
  localparam logic [3:0] OPT_DBL_ATAN    = 4'd1;
  localparam logic [3:0] OPT_UP_ATAN     = 4'd2;
  localparam logic [3:0] OPT_LO_ATAN     = 4'd3;
  localparam logic [3:0] OPT_DBL_CLIP    = 4'd4;
  localparam logic [3:0] OPT_UP_CLIP     = 4'd5;
  localparam logic [3:0] OPT_LO_CLIP     = 4'd6;
  localparam logic [3:0] OPT_UP_RESET    = 4'd7;
  localparam logic [3:0] OPT_CLIP_RESET  = 4'd8;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_DEF  = 2'd1;
  localparam logic [1:0] STAT_ALREADY  = 2'd2;
  localparam logic [1:0] STAT_ZERO_DIV = 2'd3;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic [5:0]                   entry_index;
    logic [3:0]                   option;
    logic signed [VALUE_BITS-1:0] value_a;
    logic signed [VALUE_BITS-1:0] value_b;
    logic signed [VALUE_BITS-1:0] value_c;
    logic signed [VALUE_BITS-1:0] value_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [VALUE_BITS-1:0] result;
  } out_item_t;

  typedef struct packed {
    logic                         valid;
    logic [3:0]                   option;
    logic signed [VALUE_BITS-1:0] in_c;
    logic signed [VALUE_BITS-1:0] in_h;
    logic signed [VALUE_BITS-1:0] out_c;
    logic signed [VALUE_BITS-1:0] out_h;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ISSUE, ST_DECODE, ST_WIDEN, ST_WWRITE, ST_DIV, ST_DIVEND,
    ST_OPT, ST_CORDIC, ST_SQMUL, ST_SQADD, ST_MUL, ST_ROUND, ST_SUM, ST_DONE
  } state_t;

  // arctan angle of step i in Q32
  function automatic logic [31:0] angle(input logic [CORDIC_CW-1:0] i);
    logic [32:0] pw;
    pw = 33'h1_0000_0000 >> i;
    unique case (i)
      CORDIC_CW'(0):  angle = 32'd3373259426;
      CORDIC_CW'(1):  angle = 32'd1991351318;
      CORDIC_CW'(2):  angle = 32'd1052175346;
      CORDIC_CW'(3):  angle = 32'd534100635;
      CORDIC_CW'(4):  angle = 32'd268086748;
      CORDIC_CW'(5):  angle = 32'd134174063;
      CORDIC_CW'(6):  angle = 32'd67103403;
      CORDIC_CW'(7):  angle = 32'd33553749;
      CORDIC_CW'(8):  angle = 32'd16777131;
      CORDIC_CW'(9):  angle = 32'd8388597;
      CORDIC_CW'(10): angle = 32'd4194303;
      default:        angle = pw[31:0];
    endcase
  endfunction

  // saturate to the value range
  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [48:0] v);
    if (v > 49'sh0_0000_7FFF_FFFF) begin
      sat_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (v < -49'sh0_0000_8000_0000) begin
      sat_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      sat_val = v[VALUE_BITS-1:0];
    end
  endfunction

endpackage

FILE: sv/feature_range_normalizer.sv
// feature range normaliser top level: entry table, divider, cordic and output map
`timescale 1ns / 1ps
`include "feature_range_normalizer_assert.svh"
// Use: items arrive on in_valid / in_stall / in_item, one at a time; each item
// gives exactly one result on out_valid / out_stall / out_item.
// The entry table lives in one ram with a registered read; every
// item reads its entry, modifies it and writes it back before the next item
// is taken, so no forwarding is needed.
// Normalise runs a 49-step restoring divider, one quotient bit per cycle,
// and with arctan compression a 17-step cordic after it; with enable low
// a normalise passes its input through. A new item is taken only after
// the last one has placed its result in the output register.
// Reset: synchronous, active low; afterwards the table is swept clear, one
// entry per cycle, while in_stall stays high. cfg_we writes the enable
// register; the user must write it only while the block is idle, which
// the block itself does not enforce. The result waits in an output register;
// when out_stall holds it, the next item may still be accepted and is
// worked until its own result is ready, then waits.
module feature_range_normalizer #(
  parameter int ENTRIES = frn_pkg::DEF_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  frn_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output frn_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW = $bits(frn_pkg::entry_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  frn_pkg::state_t    state_r, state_nxt;
  frn_pkg::in_item_t  item_r;
  frn_pkg::out_item_t out_item_r;
  frn_pkg::entry_t    ent, wentry;
  logic               enable_r, out_valid_r;
  logic [AW-1:0]      clr_cnt_r, ram_addr, ram_waddr;
  logic               ram_we, ram_re;
  logic [EW-1:0]      ram_rdata;
  logic [15:0]        idx_w;
  logic               in_range;
  logic [1:0]         st_r;
  logic signed [31:0] res_r, t_r;
  // divider
  logic               neg_r;
  logic [31:0]        mh_r, rem_r;
  logic [48:0]        dv_r;
  logic [frn_pkg::DIV_CW-1:0] div_cnt_r;
  logic [32:0]        trial;
  logic               ge;
  // cordic
  logic               sq_neg_r;
  logic signed [frn_pkg::CW-1:0] cx_r, cy_r, z_r, ang;
  logic [frn_pkg::CORDIC_CW-1:0] cs_cnt_r;
  logic [60:0]        sqp_r;
  // output mapping and widen
  logic signed [63:0] prod_r;
  logic signed [47:0] rnd_r;
  logic signed [32:0] wl_r, wr_r;
  logic               wempty_r;
  logic               accept;

  assign accept = in_valid && !in_stall;
  assign ent    = frn_pkg::entry_t'(ram_rdata);
  assign idx_w  = {10'd0, item_r.entry_index};
  assign in_range = int'(idx_w) < ENTRIES;
  assign ram_addr = idx_w[AW-1:0];

  frn_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frn_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) state_nxt = frn_pkg::ST_IDLE;
      end
      frn_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = frn_pkg::ST_ISSUE;
      end
      frn_pkg::ST_ISSUE: begin
        if ((item_r.opcode == frn_pkg::OP_NORM && !enable_r) ||
            item_r.opcode == frn_pkg::OP_NONE || !in_range) begin
          state_nxt = frn_pkg::ST_DONE;
        end else begin
          state_nxt = frn_pkg::ST_DECODE;
        end
      end
      frn_pkg::ST_DECODE: begin
        if (item_r.opcode == frn_pkg::OP_DEFINE || item_r.opcode == frn_pkg::OP_BLANK ||
            !ent.valid) begin
          state_nxt = frn_pkg::ST_DONE;
        end else if (item_r.opcode == frn_pkg::OP_WIDEN_IN ||
                     item_r.opcode == frn_pkg::OP_WIDEN_OUT) begin
          state_nxt = frn_pkg::ST_WIDEN;
        end else if (item_r.opcode == frn_pkg::OP_NORM) begin
          state_nxt = (ent.in_h == '0) ? frn_pkg::ST_OPT : frn_pkg::ST_DIV;
        end else begin
          state_nxt = frn_pkg::ST_DONE;
        end
      end
      frn_pkg::ST_WIDEN:  state_nxt = frn_pkg::ST_WWRITE;
      frn_pkg::ST_WWRITE: state_nxt = frn_pkg::ST_DONE;
      frn_pkg::ST_DIV: begin
        if (div_cnt_r == frn_pkg::DIV_CW'(frn_pkg::DIV_STEPS - 1)) begin
          state_nxt = frn_pkg::ST_DIVEND;
        end
      end
      frn_pkg::ST_DIVEND: state_nxt = frn_pkg::ST_OPT;
      frn_pkg::ST_OPT: begin
        if (((ent.option == frn_pkg::OPT_DBL_ATAN || ent.option == frn_pkg::OPT_UP_ATAN) &&
             t_r > frn_pkg::T95) ||
            ((ent.option == frn_pkg::OPT_DBL_ATAN || ent.option == frn_pkg::OPT_LO_ATAN) &&
             t_r < -frn_pkg::T95)) begin
          state_nxt = frn_pkg::ST_CORDIC;
        end else begin
          state_nxt = frn_pkg::ST_MUL;
        end
      end
      frn_pkg::ST_CORDIC: begin
        if (cs_cnt_r == frn_pkg::CORDIC_CW'(frn_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = frn_pkg::ST_SQMUL;
        end
      end
      frn_pkg::ST_SQMUL: state_nxt = frn_pkg::ST_SQADD;
      frn_pkg::ST_SQADD: state_nxt = frn_pkg::ST_MUL;
      frn_pkg::ST_MUL:   state_nxt = frn_pkg::ST_ROUND;
      frn_pkg::ST_ROUND: state_nxt = frn_pkg::ST_SUM;
      frn_pkg::ST_SUM:   state_nxt = frn_pkg::ST_DONE;
      frn_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = frn_pkg::ST_IDLE;
      end
      default: state_nxt = frn_pkg::ST_CLEAR;
    endcase
  end

  // control outputs and table write data
  always_comb begin
    logic signed [33:0] wsum;
    logic signed [33:0] wdiff;
    logic [33:0]        wmag;
    logic signed [32:0] ssum;
    logic signed [32:0] sdiff;
    logic [32:0]        smag;
    logic signed [31:0] nc;
    logic signed [31:0] nh;
    in_stall  = state_r != frn_pkg::ST_IDLE;
    ram_re    = state_r == frn_pkg::ST_ISSUE;
    ram_we    = 1'b0;
    ram_waddr = ram_addr;
    wentry    = ent;
    nc        = '0;
    nh        = '0;
    // widen: new centre and half-range from the registered ends
    wsum  = 34'(wl_r) + 34'(wr_r);
    wdiff = 34'(wr_r) - 34'(wl_r);
    wmag  = wdiff[33] ? 34'(-wdiff) : 34'(wdiff);
    // set: centre and half-range from the bounds
    ssum  = 33'(item_r.value_a) + 33'(item_r.value_b);
    sdiff = 33'(item_r.value_b) - 33'(item_r.value_a);
    smag  = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    unique case (state_r)
      frn_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        wentry    = '0;
      end
      frn_pkg::ST_DECODE: begin
        if (item_r.opcode == frn_pkg::OP_DEFINE || item_r.opcode == frn_pkg::OP_BLANK) begin
          ram_we = !ent.valid;
          wentry.valid = 1'b1;
          if (item_r.opcode == frn_pkg::OP_DEFINE) begin
            wentry.option = item_r.option;
            wentry.in_c   = item_r.value_a;
            wentry.in_h   = item_r.value_b;
            wentry.out_c  = item_r.value_c;
            wentry.out_h  = item_r.value_d;
          end else begin
            wentry.option = frn_pkg::OPT_LINEAR;
            wentry.in_c   = '0;
            wentry.in_h   = '0;
            wentry.out_c  = '0;
            wentry.out_h  = '0;
          end
        end else if (item_r.opcode == frn_pkg::OP_SET_IN ||
                     item_r.opcode == frn_pkg::OP_SET_OUT) begin
          ram_we = ent.valid;
          nc = ssum[32:1];
          nh = smag[32:1];
          if (item_r.opcode == frn_pkg::OP_SET_IN) begin
            wentry.in_c = nc;
            wentry.in_h = nh;
          end else begin
            wentry.out_c = nc;
            wentry.out_h = nh;
          end
        end
      end
      frn_pkg::ST_WWRITE: begin
        ram_we = 1'b1;
        if (wempty_r) begin
          nc = item_r.value_a;
          nh = '0;
        end else begin
          nc = frn_pkg::sat_val(49'(wsum >>> 1));
          nh = frn_pkg::sat_val(49'({1'b0, wmag[33:1]}));
        end
        if (item_r.opcode == frn_pkg::OP_WIDEN_IN) begin
          wentry.in_c = nc;
          wentry.in_h = nh;
        end else begin
          wentry.out_c = nc;
          wentry.out_h = nh;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // state, clearing counter, enable and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frn_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      enable_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == frn_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_we) enable_r <= cfg_wdata;
      if (state_r == frn_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider step
  assign trial = {rem_r, dv_r[48]};
  assign ge    = trial >= {1'b0, mh_r};

  // cordic angle of the current step
  assign ang = frn_pkg::CW'(frn_pkg::angle(cs_cnt_r));

  // datapath
  always_ff @(posedge clk) begin
    logic signed [32:0] dc;
    logic [32:0]        md;
    logic signed [32:0] lo_e;
    logic signed [32:0] hi_e;
    logic signed [32:0] a_e;
    logic [32:0]        lim;
    logic [32:0]        full;
    logic signed [32:0] xq;
    logic [32:0]        zc;
    logic [61:0]        sqs;
    logic signed [31:0] sq;
    logic signed [63:0] prs;
    dc   = 33'(item_r.value_a) - 33'(ent.in_c);
    md   = dc[32] ? 33'(-dc) : 33'(dc);
    a_e  = 33'(item_r.value_a);
    if (item_r.opcode == frn_pkg::OP_WIDEN_IN) begin
      lo_e = 33'(ent.in_c) - 33'(ent.in_h);
      hi_e = 33'(ent.in_c) + 33'(ent.in_h);
    end else begin
      lo_e = 33'(ent.out_c) - 33'(ent.out_h);
      hi_e = 33'(ent.out_c) + 33'(ent.out_h);
    end
    lim  = neg_r ? 33'h1_0000_0000 >> 1 : (33'h1_0000_0000 >> 1) - 33'd1;
    full = (dv_r > 49'(lim)) ? lim : dv_r[32:0];
    xq   = '0;
    zc   = z_r[frn_pkg::CW-1] ? 33'd0 : z_r[32:0];
    sqs  = 62'(sqp_r) + (62'd1 << 47);
    sq   = 32'(sqs[61:48]);
    prs  = prod_r + 64'sd32768;

    unique case (state_r)
      frn_pkg::ST_IDLE: begin
        if (accept) item_r <= in_item;
      end
      frn_pkg::ST_ISSUE: begin
        st_r  <= frn_pkg::STAT_OK;
        res_r <= '0;
        if (item_r.opcode == frn_pkg::OP_NORM && !enable_r) begin
          res_r <= item_r.value_a;
        end else if (item_r.opcode != frn_pkg::OP_NONE && !in_range) begin
          st_r <= frn_pkg::STAT_NOT_DEF;
        end
      end
      frn_pkg::ST_DECODE: begin
        if (item_r.opcode == frn_pkg::OP_DEFINE || item_r.opcode == frn_pkg::OP_BLANK) begin
          if (ent.valid) st_r <= frn_pkg::STAT_ALREADY;
        end else if (!ent.valid) begin
          st_r <= frn_pkg::STAT_NOT_DEF;
        end else if (item_r.opcode == frn_pkg::OP_NORM) begin
          if (ent.in_h == '0) begin
            st_r <= frn_pkg::STAT_ZERO_DIV;
            if (dc > 0) t_r <= {1'b0, {31{1'b1}}};
            else if (dc < 0) t_r <= {1'b1, {31{1'b0}}};
            else t_r <= '0;
          end
          neg_r     <= dc[32] ^ ent.in_h[31];
          mh_r      <= ent.in_h[31] ? 32'(-ent.in_h) : 32'(ent.in_h);
          rem_r     <= '0;
          dv_r      <= {md, 16'd0};
          div_cnt_r <= '0;
        end
        // widen: range ends with the sample folded in
        wempty_r <= (item_r.opcode == frn_pkg::OP_WIDEN_IN) ?
                    (ent.in_c == '0 && ent.in_h == '0) :
                    (ent.out_c == '0 && ent.out_h == '0);
        if (a_e < lo_e) begin
          wl_r <= a_e;
          wr_r <= hi_e;
        end else if (a_e > hi_e) begin
          wl_r <= lo_e;
          wr_r <= a_e;
        end else begin
          wl_r <= lo_e;
          wr_r <= hi_e;
        end
      end
      frn_pkg::ST_DIV: begin
        rem_r     <= ge ? 32'(trial - {1'b0, mh_r}) : trial[31:0];
        dv_r      <= {dv_r[47:0], ge};
        div_cnt_r <= div_cnt_r + frn_pkg::DIV_CW'(1);
      end
      frn_pkg::ST_DIVEND: begin
        t_r <= neg_r ? 32'(33'd0 - full) : full[31:0];
      end
      frn_pkg::ST_OPT: begin
        // arctan compression, clipping or reset
        if ((ent.option == frn_pkg::OPT_DBL_ATAN || ent.option == frn_pkg::OPT_UP_ATAN) &&
            t_r > frn_pkg::T95) begin
          xq       = 33'(t_r) - 33'(frn_pkg::T95);
          sq_neg_r <= 1'b0;
        end else if ((ent.option == frn_pkg::OPT_DBL_ATAN ||
                      ent.option == frn_pkg::OPT_LO_ATAN) && t_r < -frn_pkg::T95) begin
          xq       = -33'(frn_pkg::T95) - 33'(t_r);
          sq_neg_r <= 1'b1;
        end else begin
          unique case (ent.option)
            frn_pkg::OPT_DBL_CLIP: begin
              if (t_r < -frn_pkg::ONE) t_r <= -frn_pkg::ONE;
              else if (t_r > frn_pkg::ONE) t_r <= frn_pkg::ONE;
            end
            frn_pkg::OPT_UP_CLIP: begin
              if (t_r > frn_pkg::ONE) t_r <= frn_pkg::ONE;
            end
            frn_pkg::OPT_LO_CLIP: begin
              if (t_r < -frn_pkg::ONE) t_r <= -frn_pkg::ONE;
            end
            frn_pkg::OPT_UP_RESET: begin
              if (t_r > frn_pkg::ONE) t_r <= -frn_pkg::ONE;
            end
            frn_pkg::OPT_CLIP_RESET: begin
              if (t_r < -frn_pkg::ONE || t_r > frn_pkg::ONE) t_r <= -frn_pkg::ONE;
            end
            default: t_r <= t_r;
          endcase
        end
        cx_r     <= frn_pkg::CW'(frn_pkg::ONE);
        cy_r     <= frn_pkg::CW'(xq);
        z_r      <= '0;
        cs_cnt_r <= '0;
      end
      frn_pkg::ST_CORDIC: begin
        // vectoring step towards the x axis
        if (cy_r > 0) begin
          cx_r <= cx_r + (cy_r >>> cs_cnt_r);
          cy_r <= cy_r - (cx_r >>> cs_cnt_r);
          z_r  <= z_r + ang;
        end else begin
          cx_r <= cx_r - (cy_r >>> cs_cnt_r);
          cy_r <= cy_r + (cx_r >>> cs_cnt_r);
          z_r  <= z_r - ang;
        end
        cs_cnt_r <= cs_cnt_r + frn_pkg::CORDIC_CW'(1);
      end
      frn_pkg::ST_SQMUL: begin
        sqp_r <= 61'(zc * frn_pkg::KQ32);
      end
      frn_pkg::ST_SQADD: begin
        t_r <= sq_neg_r ? -frn_pkg::T95 - sq : frn_pkg::T95 + sq;
      end
      frn_pkg::ST_MUL: begin
        prod_r <= 64'(t_r) * 64'(ent.out_h);
      end
      frn_pkg::ST_ROUND: begin
        rnd_r <= prs[63:16];
      end
      frn_pkg::ST_SUM: begin
        res_r <= frn_pkg::sat_val(49'(rnd_r) + 49'(ent.out_c));
      end
      frn_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_item_r.status <= st_r;
          out_item_r.result <= res_r;
        end
      end
      default: begin
        t_r <= t_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `FRN_ASSERT_IMP(a_write_states, clk, rst_n, ram_we, state_r == frn_pkg::ST_CLEAR || state_r == frn_pkg::ST_DECODE || state_r == frn_pkg::ST_WWRITE, "table written outside a write state")
  `FRN_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_r == frn_pkg::ST_ISSUE, "accepted item not issued")
  `FRN_ASSERT_IMP(a_div_bound, clk, rst_n, state_r == frn_pkg::ST_DIV, div_cnt_r < frn_pkg::DIV_CW'(frn_pkg::DIV_STEPS), "divider ran past its last step")
  `FRN_ASSERT_IMP(a_zero_div_norm, clk, rst_n, state_r == frn_pkg::ST_DONE && st_r == frn_pkg::STAT_ZERO_DIV, item_r.opcode == frn_pkg::OP_NORM, "zero divisor status on a table command")

endmodule

FILE: sv/frn_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module frn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the feature range normaliser: directed table then random items
`timescale 1ns / 1ps
module testbench;
  import frn_pkg::*;

  localparam longint VMAX_L = 64'sd2147483647;
  localparam longint VMIN_L = -64'sd2147483648;
  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
  localparam longint T95_L = ((64'sd95 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] V_ONE = 32'sh0001_0000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  // model state of the rescaling table
  bit tbl_valid [64];
  logic [3:0] tbl_option [64];
  longint tbl_in_c [64];
  longint tbl_in_h [64];
  longint tbl_out_c [64];
  longint tbl_out_h [64];
  bit norm_enable = 1'b1;

  out_item_t pending_results [$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  typedef struct {
    in_item_t item;
    bit typed;
    out_item_t result;
  } stim_row_t;
  stim_row_t stim_table [$];

  feature_range_normalizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_val(longint v);
    if (v > VMAX_L) return VMAX_L;
    if (v < VMIN_L) return VMIN_L;
    return v;
  endfunction

  // arctan compression term (0.1/pi)*atan(x) by vectoring cordic
  function automatic longint atan_term(longint x);
    bit [63:0] atan_q32 [11] = '{64'd3373259426, 64'd1991351318, 64'd1052175346,
      64'd534100635, 64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
      64'd16777131, 64'd8388597, 64'd4194303};
    longint cx, cy, z, dx, dy, ang;
    bit [63:0] prod;
    cx = ONE_L;
    cy = x;
    z = 0;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      ang = (i < 11) ? longint'(atan_q32[i]) : (64'sd1 <<< (32 - i));
      if (cy > 0) begin
        cx += dx; cy -= dy; z += ang;
      end else begin
        cx -= dx; cy += dy; z -= ang;
      end
    end
    if (z < 0) z = 0;
    prod = (64'(z) * 64'd136713055 + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
    return longint'(prod);
  endfunction

  // widen a centre / half-range pair by one sample
  function automatic void widen_range(inout longint c, inout longint h, input longint a);
    longint l, r;
    if (c == 0 && h == 0) begin
      c = a;
      h = 0;
      return;
    end
    l = c - h;
    r = c + h;
    if (a < l) l = a;
    else if (a > r) r = a;
    c = clamp_val((l + r) >>> 1);
    h = clamp_val((r >= l ? r - l : l - r) >>> 1);
  endfunction

  // quotient in fixed point, truncated and saturated
  function automatic longint fx_divide(longint d, longint h, inout logic [1:0] st);
    bit [63:0] md, mh, q0, r, lim, full;
    bit neg;
    if (h == 0) begin
      st = STAT_ZERO_DIV;
      return d > 0 ? VMAX_L : (d < 0 ? VMIN_L : 0);
    end
    neg = (d < 0) != (h < 0);
    md = d < 0 ? -d : d;
    mh = h < 0 ? -h : h;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q0 = md / mh;
    r = md % mh;
    if (q0 > (lim >> FRAC_BITS)) full = lim;
    else begin
      full = (q0 << FRAC_BITS) + (r << FRAC_BITS) / mh;
      if (full > lim) full = lim;
    end
    return neg ? -longint'(full) : longint'(full);
  endfunction

  function automatic longint shape_value(logic [3:0] opt, longint t);
    bit up, lo;
    up = opt == OPT_DBL_ATAN || opt == OPT_UP_ATAN;
    lo = opt == OPT_DBL_ATAN || opt == OPT_LO_ATAN;
    if (up && t > T95_L) return T95_L + atan_term(t - T95_L);
    if (lo && t < -T95_L) return -T95_L - atan_term(-T95_L - t);
    case (opt)
      OPT_DBL_CLIP: return t < -ONE_L ? -ONE_L : (t > ONE_L ? ONE_L : t);
      OPT_UP_CLIP: return t > ONE_L ? ONE_L : t;
      OPT_LO_CLIP: return t < -ONE_L ? -ONE_L : t;
      OPT_UP_RESET: return t > ONE_L ? -ONE_L : t;
      OPT_CLIP_RESET: return (t < -ONE_L || t > ONE_L) ? -ONE_L : t;
      default: return t;
    endcase
  endfunction

  // expected result of one item, updating the table model
  function automatic out_item_t normalise_item(in_item_t it);
    out_item_t res;
    logic [1:0] st;
    longint a, b, c, d, t, p, rv;
    int idx;
    st = STAT_OK;
    rv = 0;
    idx = it.entry_index;
    a = it.value_a; b = it.value_b; c = it.value_c; d = it.value_d;
    if (it.opcode == OP_NORM && !norm_enable) begin
      rv = a;
    end else if (it.opcode == OP_DEFINE || it.opcode == OP_BLANK) begin
      if (tbl_valid[idx]) st = STAT_ALREADY;
      else begin
        tbl_valid[idx] = 1'b1;
        tbl_option[idx] = it.opcode == OP_DEFINE ? it.option : OPT_LINEAR;
        tbl_in_c[idx] = it.opcode == OP_DEFINE ? a : 0;
        tbl_in_h[idx] = it.opcode == OP_DEFINE ? b : 0;
        tbl_out_c[idx] = it.opcode == OP_DEFINE ? c : 0;
        tbl_out_h[idx] = it.opcode == OP_DEFINE ? d : 0;
      end
    end else if (it.opcode != OP_NONE && !tbl_valid[idx]) begin
      st = STAT_NOT_DEF;
    end else begin
      case (it.opcode)
        OP_WIDEN_IN: widen_range(tbl_in_c[idx], tbl_in_h[idx], a);
        OP_WIDEN_OUT: widen_range(tbl_out_c[idx], tbl_out_h[idx], a);
        OP_SET_IN: begin
          tbl_in_c[idx] = (a + b) >>> 1;
          tbl_in_h[idx] = (b >= a ? b - a : a - b) >>> 1;
        end
        OP_SET_OUT: begin
          tbl_out_c[idx] = (a + b) >>> 1;
          tbl_out_h[idx] = (b >= a ? b - a : a - b) >>> 1;
        end
        OP_NORM: begin
          t = fx_divide(a - tbl_in_c[idx], tbl_in_h[idx], st);
          t = shape_value(tbl_option[idx], t);
          p = t * tbl_out_h[idx];
          p = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          rv = clamp_val(p + tbl_out_c[idx]);
        end
        default: ;
      endcase
    end
    res.status = st;
    res.result = rv[31:0];
    return res;
  endfunction

  // result side: check accepted items, then drive the stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d result %0d",
          out_item.status, out_item.result);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fails++;
        end
        if (out_item.result !== want.result) begin
          $error("result: expected %0d, got %0d", want.result, out_item.result);
          fails++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one item; returns at the edge where it is taken
  task automatic send_item(in_item_t it, bit typed, out_item_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    begin
      out_item_t pred;
      pred = normalise_item(it);
      pending_results.push_back(typed ? fixed : pred);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_enable(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    norm_enable = v;
  endtask

  function automatic in_item_t make_item(logic [2:0] op, logic [5:0] idx, logic [3:0] opt,
    logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d);
    in_item_t it;
    it.opcode = op; it.entry_index = idx; it.option = opt;
    it.value_a = a; it.value_b = b; it.value_c = c; it.value_d = d;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, logic [1:0] st,
    logic signed [31:0] r);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.result.status = st;
    row.result.result = r;
    stim_table.push_back(row);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return V_MAX;
      1: return V_MIN;
      2: return 32'sd0;
      3: return $urandom;
      default: return 32'($urandom_range(1048576)) - 32'sd524288;
    endcase
  endfunction

  // mostly well-formed commands on a small set of entries
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.entry_index = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
    it.option = 4'($urandom_range(15));
    it.value_a = pick_value();
    it.value_b = pick_value();
    it.value_c = pick_value();
    it.value_d = pick_value();
    if (r < 45) it.opcode = OP_NORM;
    else if (r < 55) begin
      it.opcode = OP_DEFINE;
      if ($urandom_range(3) != 0) it.value_b = 32'($urandom_range(262144));
      if ($urandom_range(3) != 0) it.value_d = 32'($urandom_range(262144));
    end else if (r < 60) it.opcode = OP_BLANK;
    else if (r < 68) it.opcode = OP_WIDEN_IN;
    else if (r < 76) it.opcode = OP_WIDEN_OUT;
    else if (r < 84) it.opcode = OP_SET_IN;
    else if (r < 92) it.opcode = OP_SET_OUT;
    else if (r < 95) it.opcode = OP_NONE;
    else it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  task automatic random_phase(int n, int s_pct, int r_pct, bit en);
    drain_results();
    write_enable(en);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_item(random_item(), 1'b0, '0);
  endtask

  // timeout
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enable(1'b1);

    // directed table: undefined access, extremes, linear, arctan, clip-reset and unknown options, zero divisor
    add_row(make_item(OP_NORM, 6'd5, OPT_LINEAR, V_ONE, 0, 0, 0), 1, STAT_NOT_DEF, 0);
    add_row(make_item(OP_WIDEN_IN, 6'd5, OPT_LINEAR, V_ONE, 0, 0, 0), 1, STAT_NOT_DEF, 0);
    add_row(make_item(OP_SET_OUT, 6'd63, OPT_LINEAR, 0, V_ONE, 0, 0), 1, STAT_NOT_DEF, 0);
    add_row(make_item(OP_DEFINE, 6'd0, OPT_LINEAR, 0, V_ONE, 0, V_ONE), 1, STAT_OK, 0);
    add_row(make_item(OP_DEFINE, 6'd0, OPT_LINEAR, 0, V_ONE, 0, V_ONE), 1, STAT_ALREADY, 0);
    add_row(make_item(OP_NORM, 6'd0, OPT_LINEAR, V_ONE, 0, 0, 0), 1, STAT_OK, V_ONE);
    add_row(make_item(OP_NORM, 6'd0, OPT_LINEAR, V_MAX, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd0, OPT_LINEAR, V_MIN, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_BLANK, 6'd1, OPT_DBL_ATAN, V_MAX, V_MAX, V_MAX, V_MAX),
      1, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd1, OPT_LINEAR, 32'sd5, 0, 0, 0), 1, STAT_ZERO_DIV, 0);
    add_row(make_item(OP_NORM, 6'd1, OPT_LINEAR, 0, 0, 0, 0), 1, STAT_ZERO_DIV, 0);
    add_row(make_item(OP_WIDEN_IN, 6'd1, OPT_LINEAR, -V_ONE, 0, 0, 0), 1, STAT_OK, 0);
    add_row(make_item(OP_WIDEN_IN, 6'd1, OPT_LINEAR, 3 * V_ONE, 0, 0, 0), 1, STAT_OK, 0);
    add_row(make_item(OP_WIDEN_OUT, 6'd1, OPT_LINEAR, V_MIN, 0, 0, 0), 1, STAT_OK, 0);
    add_row(make_item(OP_SET_OUT, 6'd1, OPT_LINEAR, -2 * V_ONE, 2 * V_ONE, 0, 0),
      1, STAT_OK, 0);
    add_row(make_item(OP_SET_IN, 6'd1, OPT_LINEAR, V_MAX, V_MIN, 0, 0), 1, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd1, OPT_LINEAR, V_ONE, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_DEFINE, 6'd63, OPT_DBL_ATAN, 0, V_ONE, V_ONE, 2 * V_ONE),
      1, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd63, OPT_LINEAR, 3 * V_ONE, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd63, OPT_LINEAR, -3 * V_ONE, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_DEFINE, 6'd2, OPT_CLIP_RESET, 0, V_ONE, 0, V_ONE), 1, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd2, OPT_LINEAR, -5 * V_ONE, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_DEFINE, 6'd3, 4'd15, 0, V_MIN, V_MIN, V_MAX), 1, STAT_OK, 0);
    add_row(make_item(OP_NORM, 6'd3, OPT_LINEAR, V_MAX, 0, 0, 0), 0, STAT_OK, 0);
    add_row(make_item(OP_NONE, 6'd4, OPT_LINEAR, V_ONE, V_ONE, V_ONE, V_ONE),
      1, STAT_OK, 0);
    foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].typed,
      stim_table[i].result);

    // random phases across idling patterns and both enable settings
    random_phase(500, 6, 66, 1'b1);
    random_phase(200, 66, 6, 1'b0);
    random_phase(400, 66, 6, 1'b1);
    random_phase(250, 0, 0, 1'b1);

    // receiver holds off long enough to back up the input
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++) begin
      send_item(random_item(), 1'b0, '0);
      if (i == 50) drain_results();
    end
    random_phase(150, 0, 0, 1'b1);

    drain_results();
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
